@@ hdl/rgbhsi_pkg.sv @@
// Shared types and constants for the RGB to HSI pixel converter.
`default_nettype none

package rgbhsi_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned DEG_W       = 9;
  localparam int unsigned SAT_NUM_W   = 18;
  localparam int unsigned HUE_NUM_W   = 14;
  localparam int unsigned DIV_QUO_W   = 8;
  localparam int unsigned RECIP3      = 683;
  localparam int unsigned RECIP3_SHIFT = 11;
  localparam int unsigned PIPE_DEPTH  = DIV_QUO_W + 5;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_t;

  typedef struct packed {
    logic [DEG_W-1:0]  hue_degrees;
    logic [CHAN_W-1:0] hue_code;
    logic [CHAN_W-1:0] saturation_code;
    logic [CHAN_W-1:0] intensity_code;
  } hsi_t;

endpackage

`default_nettype wire

@@ hdl/rgb_to_hsi_pixel_converter_core.sv @@
// Top level of the RGB to HSI pixel converter pipeline.
//
// Usage:
//   Input channel: drive pix_i and raise start_i; the pixel transfer happens
//   at the rising edge where start_i is high and busy_o is low. busy_o stays
//   low, so one pixel can be taken in every cycle.
//   Result channel: done_o is high for exactly one cycle with the matching
//   hsi_o; the receiver takes it at the edge that ends that cycle.
//   Results come back in the order the pixels went in.
//   Pipeline: each result passes two front stages, eight stages of the
//   two restoring dividers and three back stages.
//   Throughput: one pixel per cycle; each divider stage resolves one
//   quotient bit, so the divider depth sets most of the latency.
//   Reset: rst_ni clears all valid bits; pixels in flight are dropped and no
//   result is shown until new pixels arrive.
//   The receiver cannot stall, so nothing in the pipeline ever holds.
`default_nettype none

module rgb_to_hsi_pixel_converter_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  rgbhsi_pkg::pix_t   pix_i,
  output logic               done_o,
  output rgbhsi_pkg::hsi_t   hsi_o
);

  import rgbhsi_pkg::*;

  localparam logic [DEG_W-1:0] HUE_BASE_RED   = DEG_W'(0);
  localparam logic [DEG_W-1:0] HUE_BASE_WRAP  = DEG_W'(360);
  localparam logic [DEG_W-1:0] HUE_BASE_GREEN = DEG_W'(120);
  localparam logic [DEG_W-1:0] HUE_BASE_BLUE  = DEG_W'(240);

  typedef struct packed {
    logic [CHAN_W-1:0] intensity;
    logic [DEG_W-1:0]  base;
    logic              neg;
  } side_t;

  // stage A: sum, extremes, hexcone sector
  logic [CHAN_W-1:0] r, g, b, mx, mn;
  logic [SUM_W-1:0]  sum_a, min3_a;
  logic [CHAN_W-1:0] x_a;
  logic [DEG_W-1:0]  base_a;
  logic              neg_a;
  logic              accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    r = pix_i.red_in;
    g = pix_i.green_in;
    b = pix_i.blue_in;
    mx = r;
    if (b > mx) mx = b;
    if (g > mx) mx = g;
    mn = r;
    if (b < mn) mn = b;
    if (g < mn) mn = g;
    sum_a  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    min3_a = SUM_W'({mn, 1'b0}) + SUM_W'(mn);
    if (mx == r) begin
      if (g >= b) begin
        x_a = g - b; base_a = HUE_BASE_RED; neg_a = 1'b0;
      end else begin
        x_a = b - g; base_a = HUE_BASE_WRAP; neg_a = 1'b1;
      end
    end else if (mx == g) begin
      base_a = HUE_BASE_GREEN;
      if (b >= r) begin
        x_a = b - r; neg_a = 1'b0;
      end else begin
        x_a = r - b; neg_a = 1'b1;
      end
    end else begin
      base_a = HUE_BASE_BLUE;
      if (r >= g) begin
        x_a = r - g; neg_a = 1'b0;
      end else begin
        x_a = g - r; neg_a = 1'b1;
      end
    end
  end

  logic              vld_a_q;
  logic [SUM_W-1:0]  sum_a_q, sdiff_a_q;
  logic [CHAN_W-1:0] x_a_q, d_a_q;
  logic [DEG_W-1:0]  base_a_q;
  logic              neg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_a_q   <= sum_a;
    sdiff_a_q <= sum_a - min3_a;
    x_a_q     <= x_a;
    d_a_q     <= mx - mn;
    base_a_q  <= base_a;
    neg_a_q   <= neg_a;
  end

  // stage B: scale numerators, guard zero divisors, intensity
  logic [2*SUM_W-1:0] int_prod;
  logic               vld_b_q;
  logic [SAT_NUM_W-1:0] sat_num_q;
  logic [SUM_W-1:0]     sat_den_q;
  logic [HUE_NUM_W-1:0] hue_num_q;
  logic [CHAN_W-1:0]    hue_den_q;
  side_t                side_b_q;

  assign int_prod = (2*SUM_W)'(sum_a_q) * (2*SUM_W)'(RECIP3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_num_q <= SAT_NUM_W'({sdiff_a_q, 8'b0}) - SAT_NUM_W'(sdiff_a_q);
    sat_den_q <= (sum_a_q == '0) ? SUM_W'(1) : sum_a_q;
    hue_num_q <= HUE_NUM_W'({x_a_q, 6'b0}) - HUE_NUM_W'({x_a_q, 2'b0});
    hue_den_q <= (d_a_q == '0) ? CHAN_W'(1) : d_a_q;
    side_b_q.intensity <= CHAN_W'(int_prod >> RECIP3_SHIFT);
    side_b_q.base      <= base_a_q;
    side_b_q.neg       <= neg_a_q;
  end

  // divider stages
  logic              sat_vld, hue_vld;
  logic [DIV_QUO_W-1:0] sat_quo, hue_quo;
  logic [SUM_W-1:0]  sat_rem;
  logic [CHAN_W-1:0] hue_rem;

  rgbhsi_div #(
    .NUM_W(SAT_NUM_W),
    .DEN_W(SUM_W),
    .QUO_W(DIV_QUO_W)
  ) u_sat_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_b_q),
    .num_i   (sat_num_q),
    .den_i   (sat_den_q),
    .valid_o (sat_vld),
    .quo_o   (sat_quo),
    .rem_o   (sat_rem)
  );

  rgbhsi_div #(
    .NUM_W(HUE_NUM_W),
    .DEN_W(CHAN_W),
    .QUO_W(DIV_QUO_W)
  ) u_hue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_b_q),
    .num_i   (hue_num_q),
    .den_i   (hue_den_q),
    .valid_o (hue_vld),
    .quo_o   (hue_quo),
    .rem_o   (hue_rem)
  );

  side_t side_q [DIV_QUO_W];

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_b_q;
    for (int i = 1; i < DIV_QUO_W; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // stage C: hue in degrees; negative sectors take the ceiling
  side_t             side_c;
  logic [DEG_W-1:0]  q_c, deg_c;
  logic              vld_c_q;
  logic [DEG_W-1:0]  deg_c_q;
  logic [CHAN_W-1:0] sat_c_q, int_c_q;

  assign side_c = side_q[DIV_QUO_W-1];
  assign q_c    = DEG_W'(hue_quo);
  assign deg_c  = side_c.neg ? (side_c.base - q_c - DEG_W'(hue_rem != '0))
                             : (side_c.base + q_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= hue_vld && sat_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    deg_c_q <= deg_c;
    sat_c_q <= (sat_den_zero_unused(sat_rem)) ? sat_quo : sat_quo;
    int_c_q <= side_c.intensity;
  end

  function automatic logic sat_den_zero_unused(input logic [SUM_W-1:0] rem);
    sat_den_zero_unused = (rem == '0);
  endfunction

  // stage D: degrees * 17 / 8
  logic              vld_d_q;
  logic [SUM_W-1:0]  t_d_q;
  logic [DEG_W-1:0]  deg_d_q;
  logic [CHAN_W-1:0] sat_d_q, int_d_q;
  logic [DEG_W+3:0]  deg17;

  assign deg17 = (DEG_W+4)'(deg_c_q) * (DEG_W+4)'(17);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_d_q   <= SUM_W'(deg17 >> 3);
    deg_d_q <= deg_c_q;
    sat_d_q <= sat_c_q;
    int_d_q <= int_c_q;
  end

  // stage E: divide by three, output register
  logic [2*SUM_W-1:0] code_prod;
  logic               done_q;
  hsi_t               hsi_q;

  assign code_prod = (2*SUM_W)'(t_d_q) * (2*SUM_W)'(RECIP3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hsi_q.hue_degrees     <= deg_d_q;
    hsi_q.hue_code        <= CHAN_W'(code_prod >> RECIP3_SHIFT);
    hsi_q.saturation_code <= sat_d_q;
    hsi_q.intensity_code  <= int_d_q;
  end

  assign done_o = done_q;
  assign hsi_o  = hsi_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(PIPE_DEPTH) done_o)
    else $error("pixel transfer without result at fixed latency");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hsi_o.hue_degrees < DEG_W'(360)) && (hsi_o.hue_code != 8'hff))
    else $error("hue out of range");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (hsi_o.saturation_code == '0) && (hsi_o.intensity_code == '0)
      |-> (hsi_o.hue_degrees == '0))
    else $error("black pixel with nonzero hue");

endmodule

`default_nettype wire

@@ hdl/rgbhsi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rgbhsi_div #(
  parameter int unsigned NUM_W = 18,
  parameter int unsigned DEN_W = 10,
  parameter int unsigned QUO_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  valid_o,
  output logic [QUO_W-1:0]      quo_o,
  output logic [DEN_W-1:0]      rem_o
);

  localparam int unsigned CW = DEN_W + QUO_W;

  logic [CW-1:0]    rem_s [QUO_W];
  logic [DEN_W-1:0] den_s [QUO_W];
  logic [QUO_W-1:0] quo_s [QUO_W];
  logic [QUO_W-1:0] vld_s;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [CW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             vld_in;
    logic [CW-1:0]    den_sh;
    logic             ge;
    logic [CW-1:0]    rem_d;
    logic [QUO_W-1:0] quo_d;
    logic [CW-1:0]    rem_q;
    logic [DEN_W-1:0] den_q;
    logic [QUO_W-1:0] quo_q;
    logic             vld_q;

    if (s == 0) begin : g_first
      assign rem_in = CW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_s[s-1];
      assign den_in = den_s[s-1];
      assign quo_in = quo_s[s-1];
      assign vld_in = vld_s[s-1];
    end

    assign den_sh = CW'(den_in) << (QUO_W - 1 - s);
    assign ge     = (rem_in >= den_sh);

    always_comb begin
      rem_d = ge ? (rem_in - den_sh) : rem_in;
      quo_d = quo_in;
      quo_d[QUO_W-1-s] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else begin
        vld_q <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q <= rem_d;
      den_q <= den_in;
      quo_q <= quo_d;
    end

    assign rem_s[s] = rem_q;
    assign den_s[s] = den_q;
    assign quo_s[s] = quo_q;
    assign vld_s[s] = vld_q;
  end

  assign valid_o = vld_s[QUO_W-1];
  assign quo_o   = quo_s[QUO_W-1];
  assign rem_o   = rem_s[QUO_W-1][DEN_W-1:0];

endmodule

`default_nettype wire
